@@ rtl/mta_pkg.sv @@
package mta_pkg;

    localparam int WINDOW_SIZE = 8;

    localparam int SAMPLE_W   = 16;
    localparam int THRESH_W   = 16;
    localparam int SUM_W      = SAMPLE_W + $clog2(WINDOW_SIZE);
    localparam int PTR_W      = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
    localparam int CNT_W      = $clog2(WINDOW_SIZE + 1);
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam int QUEUE_DEPTH = 2;
    localparam int QCNT_W     = $clog2(QUEUE_DEPTH + 1);

    localparam logic REG_TREND_THRESHOLD = 1'b0;

    typedef enum logic [1:0] {
        TREND_NONE = 2'd0,
        TREND_UP   = 2'd1,
        TREND_DOWN = 2'd2
    } mta_trend_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic [SUM_W-1:0]    sum;
        logic                window_full;
        logic                batch_end;
    } mta_item_t;

    typedef struct packed {
        mta_trend_t trend;
        logic       window_full;
        logic       batch_end;
    } mta_result_t;

endpackage

@@ rtl/mta_regs.sv @@
module mta_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [mta_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [mta_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [mta_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready,
    output logic [mta_pkg::THRESH_W-1:0]     threshold
);

    logic [mta_pkg::THRESH_W-1:0] threshold_reg;
    logic [mta_pkg::THRESH_W-1:0] threshold_next;
    logic                         sel_threshold;
    logic                         wr_en;

    assign pready        = 1'b1;
    assign sel_threshold = (paddr[mta_pkg::APB_ADDR_W-1:2] == mta_pkg::REG_TREND_THRESHOLD);
    assign wr_en         = psel && penable && pwrite && pready;

    always_comb
    begin
        threshold_next = threshold_reg;
        if (wr_en && sel_threshold)
        begin
            threshold_next = pwdata[mta_pkg::THRESH_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= '0;
        end
        else
        begin
            threshold_reg <= threshold_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (sel_threshold)
        begin
            prdata = mta_pkg::APB_DATA_W'(threshold_reg);
        end
    end

    assign threshold = threshold_reg;

endmodule

@@ rtl/mta_front.sv @@
module mta_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic [mta_pkg::SAMPLE_W-1:0]   sample,
    input  logic                           batch_end,
    output logic                           q_push,
    output mta_pkg::mta_item_t             q_item,
    input  logic                           q_full
);

    logic [mta_pkg::SAMPLE_W-1:0] ring_reg [mta_pkg::WINDOW_SIZE];
    logic [mta_pkg::PTR_W-1:0]    wp_reg;
    logic [mta_pkg::PTR_W-1:0]    wp_next;
    logic [mta_pkg::CNT_W-1:0]    fill_reg;
    logic [mta_pkg::CNT_W-1:0]    fill_next;
    logic [mta_pkg::SUM_W-1:0]    sum_reg;
    logic [mta_pkg::SUM_W-1:0]    sum_next;
    logic [mta_pkg::SUM_W-1:0]    evict;
    logic                         accept;
    logic                         was_full;

    assign full     = q_full;
    assign accept   = push && !q_full;
    assign was_full = (fill_reg == mta_pkg::CNT_W'(mta_pkg::WINDOW_SIZE));

    always_comb
    begin
        evict = '0;
        if (was_full)
        begin
            evict = mta_pkg::SUM_W'(ring_reg[wp_reg]);
        end
        sum_next = sum_reg - evict + mta_pkg::SUM_W'(sample);

        if (wp_reg == mta_pkg::PTR_W'(mta_pkg::WINDOW_SIZE - 1))
        begin
            wp_next = '0;
        end
        else
        begin
            wp_next = wp_reg + 1'b1;
        end

        if (was_full)
        begin
            fill_next = fill_reg;
        end
        else
        begin
            fill_next = fill_reg + 1'b1;
        end
    end

    // oldest sample out, new one in, same cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg   <= '0;
            fill_reg <= '0;
            sum_reg  <= '0;
        end
        else if (accept)
        begin
            wp_reg   <= wp_next;
            fill_reg <= fill_next;
            sum_reg  <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ring_reg[wp_reg] <= sample;
        end
    end

    always_comb
    begin
        q_push             = accept;
        q_item.sample      = sample;
        q_item.sum         = sum_next;
        q_item.window_full = (fill_next == mta_pkg::CNT_W'(mta_pkg::WINDOW_SIZE));
        q_item.batch_end   = batch_end;
    end

    a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= mta_pkg::CNT_W'(mta_pkg::WINDOW_SIZE))
        else $error("fill count beyond window size");

endmodule

@@ rtl/mta_queue.sv @@
module mta_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  mta_pkg::mta_item_t   wr_item,
    output logic                 full,
    input  logic                 rd_en,
    output mta_pkg::mta_item_t   rd_item,
    output logic                 empty
);

    mta_pkg::mta_item_t           mem_reg [mta_pkg::QUEUE_DEPTH];
    logic                         wr_ptr_reg;
    logic                         rd_ptr_reg;
    logic [mta_pkg::QCNT_W-1:0]   cnt_reg;
    logic [mta_pkg::QCNT_W-1:0]   cnt_next;
    logic                         do_wr;
    logic                         do_rd;

    assign full  = (cnt_reg == mta_pkg::QCNT_W'(mta_pkg::QUEUE_DEPTH));
    assign empty = (cnt_reg == '0);
    assign do_wr = wr_en && !full;
    assign do_rd = rd_en && !empty;

    assign rd_item = mem_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg + mta_pkg::QCNT_W'(do_wr) - mta_pkg::QCNT_W'(do_rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

@@ rtl/mta_back.sv @@
module mta_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           q_empty,
    input  mta_pkg::mta_item_t             q_item,
    output logic                           q_pop,
    input  logic [mta_pkg::THRESH_W-1:0]   threshold,
    output logic                           empty,
    input  logic                           pop,
    output logic [1:0]                     trend,
    output logic                           window_full,
    output logic                           batch_end_out
);

    mta_pkg::mta_trend_t          trend_reg;
    mta_pkg::mta_trend_t          trend_next;
    mta_pkg::mta_trend_t          trend_calc;
    mta_pkg::mta_result_t         res_reg [mta_pkg::QUEUE_DEPTH];
    mta_pkg::mta_result_t         res_new;
    mta_pkg::mta_result_t         res_head;
    logic                         wr_ptr_reg;
    logic                         rd_ptr_reg;
    logic [mta_pkg::QCNT_W-1:0]   cnt_reg;
    logic [mta_pkg::QCNT_W-1:0]   cnt_next;
    logic [mta_pkg::SAMPLE_W-1:0] mean;
    logic [mta_pkg::SAMPLE_W-1:0] diff;
    logic                         out_full;
    logic                         out_pop;

    assign out_full = (cnt_reg == mta_pkg::QCNT_W'(mta_pkg::QUEUE_DEPTH));
    assign empty    = (cnt_reg == '0);
    assign q_pop    = !q_empty && !out_full;
    assign out_pop  = pop && !empty;

    always_comb
    begin
        mean = mta_pkg::SAMPLE_W'(q_item.sum / mta_pkg::SUM_W'(mta_pkg::WINDOW_SIZE));
        if (q_item.sample >= mean)
        begin
            diff = q_item.sample - mean;
        end
        else
        begin
            diff = mean - q_item.sample;
        end

        priority if (diff <= threshold)
        begin
            trend_calc = mta_pkg::TREND_NONE;
        end
        else if (q_item.sample > mean)
        begin
            trend_calc = mta_pkg::TREND_UP;
        end
        else
        begin
            trend_calc = mta_pkg::TREND_DOWN;
        end

        // trend holds until the window has filled
        trend_next = q_item.window_full ? trend_calc : trend_reg;

        res_new.trend       = trend_next;
        res_new.window_full = q_item.window_full;
        res_new.batch_end   = q_item.batch_end;

        cnt_next = cnt_reg + mta_pkg::QCNT_W'(q_pop) - mta_pkg::QCNT_W'(out_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trend_reg  <= mta_pkg::TREND_NONE;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (q_pop)
            begin
                trend_reg  <= trend_next;
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (out_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            res_reg[wr_ptr_reg] <= res_new;
        end
    end

    assign res_head      = res_reg[rd_ptr_reg];
    assign trend         = res_head.trend;
    assign window_full   = res_head.window_full;
    assign batch_end_out = res_head.batch_end;

    a_cnt_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= mta_pkg::QCNT_W'(mta_pkg::QUEUE_DEPTH))
        else $error("result buffer overflow");

    a_hold_before_full: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && !q_item.window_full) |=> $stable(trend_reg))
        else $error("trend changed before window full");

    a_no_trend_at_mean: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && q_item.window_full && (diff <= threshold))
        |=> (trend_reg == mta_pkg::TREND_NONE))
        else $error("trend set within threshold");

    a_cnt_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && !out_pop) |=> (cnt_reg == $past(cnt_reg) + 1'b1))
        else $error("result count lost a request");

endmodule

@@ rtl/moving_average_trend_detector.sv @@
// an accepted request is queued, then its result goes to the buffer behind the result ports
// throughput: one request per cycle while full is low, limited by the running sum update
// a two-entry queue sits between front and back, another one holds results
// rst_n is asynchronous, active low: clears sum, fill count, pointers, trend and threshold
// sample ring contents are not cleared and are read only once the window is full
module moving_average_trend_detector (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    output logic                             full,
    input  logic [mta_pkg::SAMPLE_W-1:0]     sample,
    input  logic                             batch_end,
    output logic                             empty,
    input  logic                             pop,
    output logic [1:0]                       trend,
    output logic                             window_full,
    output logic                             batch_end_out,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [mta_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [mta_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [mta_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready
);

    logic [mta_pkg::THRESH_W-1:0] threshold;
    logic                         q_push;
    logic                         q_full;
    logic                         q_pop;
    logic                         q_empty;
    mta_pkg::mta_item_t           q_wr_item;
    mta_pkg::mta_item_t           q_rd_item;

    mta_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .threshold (threshold)
    );

    mta_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .sample    (sample),
        .batch_end (batch_end),
        .q_push    (q_push),
        .q_item    (q_wr_item),
        .q_full    (q_full)
    );

    mta_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_item (q_wr_item),
        .full    (q_full),
        .rd_en   (q_pop),
        .rd_item (q_rd_item),
        .empty   (q_empty)
    );

    mta_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_item        (q_rd_item),
        .q_pop         (q_pop),
        .threshold     (threshold),
        .empty         (empty),
        .pop           (pop),
        .trend         (trend),
        .window_full   (window_full),
        .batch_end_out (batch_end_out)
    );

endmodule

@@ bench/tb_moving_average_trend_detector.sv @@
`timescale 1ns / 1ps

module tb_moving_average_trend_detector;

    localparam logic [mta_pkg::APB_ADDR_W-1:0] ADDR_THRESHOLD =
        mta_pkg::APB_ADDR_W'(4 * mta_pkg::REG_TREND_THRESHOLD);
    localparam logic [mta_pkg::APB_ADDR_W-1:0] ADDR_UNMAPPED  = mta_pkg::APB_ADDR_W'(4);

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           push = 1'b0;
    logic                           full;
    logic [mta_pkg::SAMPLE_W-1:0]   sample = '0;
    logic                           batch_end = 1'b0;
    logic                           empty;
    logic                           pop = 1'b0;
    logic [1:0]                     trend;
    logic                           window_full;
    logic                           batch_end_out;
    logic                           psel = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite = 1'b0;
    logic [mta_pkg::APB_ADDR_W-1:0] paddr = '0;
    logic [mta_pkg::APB_DATA_W-1:0] pwdata = '0;
    logic [mta_pkg::APB_DATA_W-1:0] prdata;
    logic                           pready;

    // predictor state
    logic [mta_pkg::SAMPLE_W-1:0] ring [mta_pkg::WINDOW_SIZE];
    int                           wr_slot = 0;
    int                           seen = 0;
    logic [mta_pkg::SUM_W-1:0]    window_sum = '0;
    mta_pkg::mta_trend_t          trend_now = mta_pkg::TREND_NONE;
    logic [mta_pkg::THRESH_W-1:0] threshold = '0;

    mta_pkg::mta_result_t pending_trends[$];
    mta_pkg::mta_result_t want;
    int                   mismatches = 0;
    int                   tx_idle_pct = 0;
    int                   rx_idle_pct = 0;
    int                   rx_hold_left = 0;

    moving_average_trend_detector u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .sample        (sample),
        .batch_end     (batch_end),
        .empty         (empty),
        .pop           (pop),
        .trend         (trend),
        .window_full   (window_full),
        .batch_end_out (batch_end_out),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic mta_pkg::mta_result_t advance_window(
        input logic [mta_pkg::SAMPLE_W-1:0] s,
        input logic be);
        mta_pkg::mta_result_t      r;
        logic [mta_pkg::SUM_W-1:0] mean;
        logic [mta_pkg::SUM_W-1:0] diff;
        if (seen == mta_pkg::WINDOW_SIZE)
            window_sum = window_sum - ring[wr_slot];
        window_sum = window_sum + s;
        ring[wr_slot] = s;
        wr_slot = (wr_slot == mta_pkg::WINDOW_SIZE - 1) ? 0 : wr_slot + 1;
        if (seen < mta_pkg::WINDOW_SIZE)
            seen++;
        if (seen == mta_pkg::WINDOW_SIZE)
        begin
            mean = window_sum / mta_pkg::WINDOW_SIZE;
            diff = (s >= mean) ? s - mean : mean - s;
            if (diff > threshold)
                trend_now = (s > mean) ? mta_pkg::TREND_UP : mta_pkg::TREND_DOWN;
            else
                trend_now = mta_pkg::TREND_NONE;
        end
        r.trend = trend_now;
        r.window_full = (seen == mta_pkg::WINDOW_SIZE);
        r.batch_end = be;
        return r;
    endfunction

    // receiver: random pops, long hold-off on demand, in-order compare
    always @(posedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else if (rx_hold_left > 0)
        begin
            pop <= 1'b0;
            rx_hold_left--;
        end
        else
            pop <= ($urandom_range(99) >= rx_idle_pct);

        if (rst_n && pop && !empty)
        begin
            if (pending_trends.size() == 0)
            begin
                $display("%0t: result with no request waiting: trend %0d full %0b batch_end %0b",
                         $time, trend, window_full, batch_end_out);
                mismatches++;
            end
            else
            begin
                want = pending_trends.pop_front();
                if (trend !== want.trend)
                begin
                    $display("%0t: trend expected %0d actual %0d", $time, want.trend, trend);
                    mismatches++;
                end
                if (window_full !== want.window_full)
                begin
                    $display("%0t: window_full expected %0b actual %0b",
                             $time, want.window_full, window_full);
                    mismatches++;
                end
                if (batch_end_out !== want.batch_end)
                begin
                    $display("%0t: batch_end_out expected %0b actual %0b",
                             $time, want.batch_end, batch_end_out);
                    mismatches++;
                end
            end
        end
    end

    task automatic send_sample(input logic [mta_pkg::SAMPLE_W-1:0] s, input logic be);
        while (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        sample <= s;
        batch_end <= be;
        do
            @(posedge clk);
        while (full);
        pending_trends.push_back(advance_window(s, be));
    endtask

    task automatic wait_idle();
        push <= 1'b0;
        while (pending_trends.size() > 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apb_write(input logic [mta_pkg::APB_ADDR_W-1:0] addr,
                             input logic [mta_pkg::APB_DATA_W-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        if (addr == ADDR_THRESHOLD)
            threshold = data[mta_pkg::THRESH_W-1:0];
        @(posedge clk);
    endtask

    task automatic check_threshold_readback();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= ADDR_THRESHOLD;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== mta_pkg::APB_DATA_W'(threshold))
        begin
            $display("%0t: threshold readback expected %0h actual %0h",
                     $time, threshold, prdata);
            mismatches++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_threshold(input logic [mta_pkg::APB_DATA_W-1:0] data);
        wait_idle();
        apb_write(ADDR_THRESHOLD, data);
        check_threshold_readback();
    endtask

    task automatic test_register_access();
        check_threshold_readback();
        apb_write(ADDR_UNMAPPED, '1);
        check_threshold_readback();
        set_threshold(32'hFFFF_5A5A);
        set_threshold(32'h0000_FFFF);
        set_threshold(32'h0);
    endtask

    // first samples fill the window, then extremes and a flat window
    task automatic test_window_fill();
        for (int k = 0; k < mta_pkg::WINDOW_SIZE; k++)
            send_sample((k % 2) ? 16'h0000 : 16'hFFFF, k[0]);
        send_sample(16'hFFFF, 1'b1);
        send_sample(16'h0000, 1'b0);
        for (int k = 0; k < mta_pkg::WINDOW_SIZE; k++)
            send_sample(16'd1234, (k == mta_pkg::WINDOW_SIZE - 1));
    endtask

    task automatic test_threshold_extremes();
        set_threshold(32'h0000_FFFF);
        send_sample(16'h0000, 1'b0);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'h0000, 1'b1);
        set_threshold(32'd1);
        for (int k = 0; k < mta_pkg::WINDOW_SIZE; k++)
            send_sample(16'd1234, 1'b0);
        send_sample(16'd1235, 1'b0);
        send_sample(16'd1236, 1'b1);
    endtask

    // receiver holds off while requests keep coming so the input stalls
    task automatic test_backpressure();
        set_threshold(32'd200);
        tx_idle_pct = 0;
        rx_hold_left = 80;
        for (int k = 0; k < 30; k++)
            send_sample(16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
        wait_idle();
    endtask

    task automatic test_random_stream(input int count,
                                      input logic [mta_pkg::THRESH_W-1:0] thr,
                                      input int tx_pct, input int rx_pct);
        int level;
        int spread;
        int v;
        int pick;
        set_threshold(mta_pkg::APB_DATA_W'(thr));
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        level = $urandom_range(0, 65535);
        spread = (thr > 16000) ? 40000 : 2 * thr + 16;
        for (int k = 0; k < count; k++)
        begin
            if (k % 16 == 0 && $urandom_range(0, 3) == 0)
                level = $urandom_range(0, 65535);
            pick = $urandom_range(0, 99);
            if (pick < 8)
                v = $urandom_range(0, 65535);
            else if (pick < 12)
                v = pick[0] ? 65535 : 0;
            else
                v = level + $urandom_range(0, 2 * spread) - spread;
            if (v < 0)
                v = 0;
            if (v > 65535)
                v = 65535;
            send_sample(16'(v), ($urandom_range(0, 7) == 0));
        end
        wait_idle();
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_register_access();
        test_window_fill();
        test_threshold_extremes();
        test_random_stream(200, 16'd0, 0, 0);
        test_backpressure();
        test_random_stream(250, 16'd16, 37, 37);
        test_random_stream(250, 16'd300, 37, 37);
        test_random_stream(250, 16'd4000, 37, 37);
        test_random_stream(250, 16'($urandom_range(0, 65535)), 37, 37);
        test_random_stream(200, 16'hFFFF, 37, 37);
        repeat (8) @(posedge clk);
        if (mismatches == 0 && pending_trends.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/mta_pkg.sv
rtl/mta_regs.sv
rtl/mta_front.sv
rtl/mta_queue.sv
rtl/mta_back.sv
rtl/moving_average_trend_detector.sv
bench/tb_moving_average_trend_detector.sv
